@@ rtl/core/box_frustum_cull_assert.svh @@
// assertion macros for the box culling checker
`ifndef BOX_FRUSTUM_CULL_ASSERT_SVH
`define BOX_FRUSTUM_CULL_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("box_frustum_cull: implication check failed");

// next-cycle implication, disabled while reset is low
`define BFC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("box_frustum_cull: next-cycle check failed");

`endif

@@ rtl/core/bfc_pkg.sv @@
// shared constants and types for the box frustum culling block
`timescale 1ns / 1ps

package bfc_pkg;

    // number formats
    localparam int unsigned COORD_BITS      = 16;
    localparam int unsigned COEFF_FRAC_BITS = 16;
    localparam int unsigned COEFF_BITS      = 32;
    localparam int unsigned SUM_W           = COORD_BITS + 1;
    localparam int unsigned PROD_W          = COEFF_BITS + SUM_W;
    localparam int unsigned ACC_W           = PROD_W + 2;

    // register file layout
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned REG_SEL_W   = $clog2(NUM_REGS);
    localparam int unsigned REG_SEL_LSB = $clog2(CFG_W / 8);
    localparam int unsigned ADDR_W      = REG_SEL_W + REG_SEL_LSB;
    localparam int unsigned NUM_ROWS    = 4;
    localparam int unsigned NUM_COLS    = 4;
    localparam int unsigned REG_PER_ROW = 2;

    typedef logic [CFG_W-1:0] t_cfg_word;
    typedef t_cfg_word t_cfg_regs [NUM_REGS];

    // register indexes
    typedef enum logic [REG_SEL_W-1:0] {
        REG_ROW0_C01,
        REG_ROW0_C23,
        REG_ROW1_C01,
        REG_ROW1_C23,
        REG_ROW2_C01,
        REG_ROW2_C23,
        REG_ROW3_C01,
        REG_ROW3_C23
    } t_reg_idx;

    // identity transform at reset
    localparam t_cfg_word COEFF_ONE = t_cfg_word'(1) << COEFF_FRAC_BITS;
    localparam t_cfg_word COEFF_ONE_HI = COEFF_ONE << COEFF_BITS;
    localparam t_cfg_regs CFG_RESET = '{
        COEFF_ONE, '0, COEFF_ONE_HI, '0, '0, COEFF_ONE, '0, COEFF_ONE_HI
    };

    // cull flag bits
    localparam int unsigned FLAG_LEFT   = 0;
    localparam int unsigned FLAG_RIGHT  = 1;
    localparam int unsigned FLAG_BOTTOM = 2;
    localparam int unsigned FLAG_TOP    = 3;
    localparam int unsigned FLAG_NEAR   = 4;
    localparam int unsigned FLAG_FAR    = 5;
    localparam int unsigned FLAG_FRONT  = 6;
    localparam int unsigned FLAG_BEHIND = 7;
    localparam logic [7:0]  FLAGS_ARMED = 8'h3F;
    localparam logic [7:0]  PLANE_MASK  = 8'h3F;

    // one transformed vertex in clip space
    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
        logic signed [ACC_W-1:0] w;
        logic                    last;
    } t_clip;

endpackage

@@ rtl/core/bfc_cfg.sv @@
// transform coefficient registers behind the configuration port
`timescale 1ns / 1ps

module bfc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfc_pkg::ADDR_W-1:0]      paddr,
    input  logic [bfc_pkg::CFG_W-1:0]       pwdata,
    output logic [bfc_pkg::CFG_W-1:0]       prdata,
    output logic                            pready,
    output bfc_pkg::t_cfg_regs              o_cfg
);

    bfc_pkg::t_cfg_regs                 r_cfg;
    logic [bfc_pkg::REG_SEL_W-1:0]      w_sel;
    logic                               w_wr;

    assign w_sel  = paddr[bfc_pkg::ADDR_W-1:bfc_pkg::REG_SEL_LSB];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = r_cfg[w_sel];
    assign o_cfg  = r_cfg;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bfc_pkg::CFG_RESET;
        end else if (w_wr) begin
            r_cfg[w_sel] <= pwdata;
        end
    end

endmodule

@@ rtl/core/bfc_xform.sv @@
// translate and clip transform pipeline: input, product and sum stages
`timescale 1ns / 1ps

module bfc_xform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bfc_pkg::t_cfg_regs                  i_cfg,
    input  logic                                i_valid,
    output logic                                o_rdy,
    input  logic signed [bfc_pkg::COORD_BITS-1:0] i_vertex_x,
    input  logic signed [bfc_pkg::COORD_BITS-1:0] i_vertex_y,
    input  logic signed [bfc_pkg::COORD_BITS-1:0] i_vertex_z,
    input  logic signed [bfc_pkg::COORD_BITS-1:0] i_shift_x,
    input  logic signed [bfc_pkg::COORD_BITS-1:0] i_shift_y,
    input  logic signed [bfc_pkg::COORD_BITS-1:0] i_shift_z,
    input  logic                                i_last_vertex,
    output logic                                o_valid,
    input  logic                                i_rdy,
    output bfc_pkg::t_clip                      o_clip
);

    localparam int unsigned NR = bfc_pkg::NUM_ROWS;
    localparam int unsigned NC = bfc_pkg::NUM_COLS;

    // stage 1: translated vertex
    logic                               r_vld1;
    logic                               r_last1;
    logic signed [bfc_pkg::SUM_W-1:0]   r_pos [3];

    // stage 2: coefficient products
    logic                               r_vld2;
    logic                               r_last2;
    logic signed [bfc_pkg::PROD_W-1:0]  r_prod [NR][3];

    // stage 3: clip coordinates
    logic                               r_vld3;
    bfc_pkg::t_clip                     r_clip;

    logic                               w_rdy1;
    logic                               w_rdy2;
    logic                               w_rdy3;
    logic signed [bfc_pkg::COEFF_BITS-1:0] w_coef [NR][NC];
    logic signed [bfc_pkg::ACC_W-1:0]   w_acc [NR];

    // stall chain, bubbles collapse
    assign w_rdy3 = !r_vld3 || i_rdy;
    assign w_rdy2 = !r_vld2 || w_rdy3;
    assign w_rdy1 = !r_vld1 || w_rdy2;
    assign o_rdy  = w_rdy1;

    // unpack signed coefficients from the row register pairs
    always_comb begin
        for (int r = 0; r < NR; r++) begin
            for (int c = 0; c < NC; c++) begin
                w_coef[r][c] = bfc_pkg::COEFF_BITS'(
                    i_cfg[r * bfc_pkg::REG_PER_ROW + c / 2]
                        >> ((c % 2) * bfc_pkg::COEFF_BITS));
            end
        end
    end

    // row sums plus the constant column
    always_comb begin
        for (int r = 0; r < NR; r++) begin
            w_acc[r] = bfc_pkg::ACC_W'(r_prod[r][0]) + bfc_pkg::ACC_W'(r_prod[r][1])
                     + bfc_pkg::ACC_W'(r_prod[r][2]) + bfc_pkg::ACC_W'(w_coef[r][NC-1]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_vld1 <= i_valid;
            end
            if (w_rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (w_rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_pos[0] <= bfc_pkg::SUM_W'(i_vertex_x) + bfc_pkg::SUM_W'(i_shift_x);
            r_pos[1] <= bfc_pkg::SUM_W'(i_vertex_y) + bfc_pkg::SUM_W'(i_shift_y);
            r_pos[2] <= bfc_pkg::SUM_W'(i_vertex_z) + bfc_pkg::SUM_W'(i_shift_z);
            r_last1  <= i_last_vertex;
        end
        if (w_rdy2 && r_vld1) begin
            for (int r = 0; r < NR; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= bfc_pkg::PROD_W'(w_coef[r][c] * r_pos[c]);
                end
            end
            r_last2 <= r_last1;
        end
        if (w_rdy3 && r_vld2) begin
            r_clip.x    <= w_acc[0];
            r_clip.y    <= w_acc[1];
            r_clip.z    <= w_acc[2];
            r_clip.w    <= w_acc[3];
            r_clip.last <= r_last2;
        end
    end

    assign o_valid = r_vld3;
    assign o_clip  = r_clip;

endmodule

@@ rtl/core/bfc_cull.sv @@
// plane tests, cull flag accumulation and the result register
`timescale 1ns / 1ps

module bfc_cull (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_rdy,
    input  bfc_pkg::t_clip  i_clip,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_visible
);

    logic [7:0]                         r_flags;
    logic                               r_o_valid;
    logic                               r_visible;
    logic [7:0]                         w_flags;
    logic signed [bfc_pkg::ACC_W-1:0]   w_negw;
    logic                               w_vis;
    logic                               w_take;

    assign o_rdy  = !r_o_valid || !i_stall;
    assign w_take = i_valid && o_rdy;
    assign w_negw = -i_clip.w;

    // flag update for this vertex
    always_comb begin
        w_flags = r_flags;
        if (i_clip.w <= 0) begin
            w_flags[bfc_pkg::FLAG_BEHIND] = 1'b1;
        end else begin
            w_flags[bfc_pkg::FLAG_FRONT] = 1'b1;
            if (i_clip.x >= w_negw)   w_flags[bfc_pkg::FLAG_LEFT]   = 1'b0;
            if (i_clip.x <= i_clip.w) w_flags[bfc_pkg::FLAG_RIGHT]  = 1'b0;
            if (i_clip.y >= w_negw)   w_flags[bfc_pkg::FLAG_BOTTOM] = 1'b0;
            if (i_clip.y <= i_clip.w) w_flags[bfc_pkg::FLAG_TOP]    = 1'b0;
            if (i_clip.z >= w_negw)   w_flags[bfc_pkg::FLAG_NEAR]   = 1'b0;
            if (i_clip.z <= i_clip.w) w_flags[bfc_pkg::FLAG_FAR]    = 1'b0;
        end
    end

    // box decision: straddling w=0 is visible, all behind is culled, else the plane tests decide
    always_comb begin
        if (w_flags[bfc_pkg::FLAG_BEHIND] && w_flags[bfc_pkg::FLAG_FRONT]) begin
            w_vis = 1'b1;
        end else if (!w_flags[bfc_pkg::FLAG_FRONT]) begin
            w_vis = 1'b0;
        end else begin
            w_vis = ~|(w_flags & bfc_pkg::PLANE_MASK);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= bfc_pkg::FLAGS_ARMED;
            r_o_valid <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_o_valid <= i_valid && i_clip.last;
            end
            if (w_take) begin
                r_flags <= i_clip.last ? bfc_pkg::FLAGS_ARMED : w_flags;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take && i_clip.last) begin
            r_visible <= w_vis;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_visible = r_visible;

endmodule

@@ rtl/core/box_frustum_cull.sv @@
// top level of the box frustum culling block
`timescale 1ns / 1ps

// Box frustum culling: one box corner is accepted per clock while the result side is
// not stalled; each corner gets its translation added, goes through the 4x4 Q16.16
// clip transform and is tested against the six clip planes. The corner marked last
// produces one visible bit, passed through the input, product, row-sum and result
// registers. Throughput is set by the four-deep pipeline with its twelve parallel
// 32x17 multipliers: one vertex per cycle while the result side is not stalled. The
// coefficient registers sit at byte offsets 8*i, 64 bits each; the user must write
// them only while no vertex is in flight, which the block does not enforce.
module box_frustum_cull (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [bfc_pkg::ADDR_W-1:0]              paddr,
    input  logic [bfc_pkg::CFG_W-1:0]               pwdata,
    output logic [bfc_pkg::CFG_W-1:0]               prdata,
    output logic                                    pready,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [bfc_pkg::COORD_BITS-1:0]   i_vertex_x,
    input  logic signed [bfc_pkg::COORD_BITS-1:0]   i_vertex_y,
    input  logic signed [bfc_pkg::COORD_BITS-1:0]   i_vertex_z,
    input  logic signed [bfc_pkg::COORD_BITS-1:0]   i_shift_x,
    input  logic signed [bfc_pkg::COORD_BITS-1:0]   i_shift_y,
    input  logic signed [bfc_pkg::COORD_BITS-1:0]   i_shift_z,
    input  logic                                    i_last_vertex,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_visible
);

    bfc_pkg::t_cfg_regs w_cfg;
    bfc_pkg::t_clip     w_clip;
    logic               w_clip_valid;
    logic               w_clip_rdy;
    logic               w_in_rdy;

    assign o_stall = !w_in_rdy;

    // coefficient registers
    bfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // translate and transform
    bfc_xform u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .o_rdy         (w_in_rdy),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_shift_x     (i_shift_x),
        .i_shift_y     (i_shift_y),
        .i_shift_z     (i_shift_z),
        .i_last_vertex (i_last_vertex),
        .o_valid       (w_clip_valid),
        .i_rdy         (w_clip_rdy),
        .o_clip        (w_clip)
    );

    // plane tests and decision
    bfc_cull u_cull (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_clip_valid),
        .o_rdy     (w_clip_rdy),
        .i_clip    (w_clip),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_visible (o_visible)
    );

endmodule

@@ rtl/core/bfc_checker.sv @@
// port-level checks for the box frustum culling block, bound to the top level
`timescale 1ns / 1ps
`include "box_frustum_cull_assert.svh"

module bfc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic o_stall,
    input  logic o_valid,
    input  logic i_stall,
    input  logic o_visible
);

    // a stalled result stays offered
    `BFC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // a stalled result keeps its value
    `BFC_ASSERT_NXT(a_vis_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_visible))

    // input back-pressure only when a result is pending and stalled
    `BFC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // no result in the cycle right after reset
    `BFC_ASSERT_IMP(a_rst_empty, i_clk, i_rst_n, !$past(i_rst_n), !o_valid)

endmodule

bind box_frustum_cull bfc_checker u_bfc_checker (.*);
